// ===== rtl/kpu_pkg.sv =====
// kpu_pkg: shared widths, the front-to-back job type and the factorial table function
// for the permutation unranking core. Depends on nothing.
`timescale 1ns / 1ps

package kpu_pkg;

	localparam int SIZE_W    = 4;
	localparam int RANK_W    = 19;
	localparam int DIGIT_W   = 4;
	localparam int MAX_N_DEF = 9;
	localparam int SIZE_MAX  = (1 << SIZE_W) - 1;

	localparam longint FACT_SAT = longint'(1) << RANK_W;

	typedef struct packed {
		logic [SIZE_W-1:0] n;
		logic [RANK_W-1:0] rank;
		logic              err;
	} job_t;

	// j * r!, saturated at 2^RANK_W (above any 0-based rank)
	function automatic logic [RANK_W:0] mult_fact_sat(input int r, input int j);
		longint p;
		p = longint'(j);
		if (p > FACT_SAT) begin
			p = FACT_SAT;
		end
		for (int i = 2; i <= r; i++) begin
			p = p * longint'(i);
			if (p > FACT_SAT) begin
				p = FACT_SAT;
			end
		end
		return p[RANK_W:0];
	endfunction

endpackage

// ===== rtl/kpu_front.sv =====
// kpu_front: accepts items, saturates the size, checks the rank against n! and
// holds classified jobs in a two-entry queue. Depends on kpu_pkg.
`timescale 1ns / 1ps

module kpu_front
	import kpu_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [SIZE_W-1:0] perm_size,
	input  logic [RANK_W-1:0] perm_rank,
	output logic              job_valid,
	input  logic              job_pop,
	output job_t              job
);

	localparam int NEFF  = (MAX_N < SIZE_MAX) ? MAX_N : SIZE_MAX;
	localparam int NW    = $clog2(NEFF + 1);
	localparam int DEPTH = 2;

	logic [RANK_W:0] fact_tab [0:NEFF];

	for (genvar g = 0; g <= NEFF; g++) begin : g_fact
		assign fact_tab[g] = mult_fact_sat(g, 1);
	end

	logic [SIZE_W-1:0] n_sat;
	logic              err;
	job_t              job_in;
	logic              accept;
	logic              wr_en;
	logic              rd_en;

	job_t slot_q [0:DEPTH-1];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;

	always_comb begin
		n_sat = (perm_size > SIZE_W'(NEFF)) ? SIZE_W'(NEFF) : perm_size;
		err = (perm_rank == '0) || ({1'b0, perm_rank} > fact_tab[n_sat[NW-1:0]]);
		job_in.n = n_sat;
		job_in.err = err;
		job_in.rank = err ? '0 : perm_rank - 1'b1;
	end

	assign full      = (cnt_q == 2'(DEPTH));
	assign accept    = push && !full;
	// size zero gives no digits, so nothing is queued
	assign wr_en     = accept && (n_sat != '0);
	assign job_valid = (cnt_q != '0);
	assign rd_en     = job_pop && job_valid;
	assign job       = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= job_in;
		end
	end

endmodule

// ===== rtl/kpu_back.sv =====
// kpu_back: digit sequencer. One factorial digit per unstalled cycle from the rank,
// then selection of the unused element into the result register. Depends on kpu_pkg.
`timescale 1ns / 1ps

module kpu_back
	import kpu_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_pop,
	input  job_t               job,
	output logic               empty,
	input  logic               pop,
	output logic [DIGIT_W-1:0] digit,
	output logic               last_digit,
	output logic               rank_error
);

	localparam int NEFF = (MAX_N < SIZE_MAX) ? MAX_N : SIZE_MAX;
	localparam int IW   = (NEFF > 1) ? $clog2(NEFF) : 1;

	// thr[r][j] = j * r!, saturated
	logic [RANK_W:0] thr [0:NEFF-1][0:NEFF-1];

	for (genvar r = 0; r < NEFF; r++) begin : g_row
		for (genvar j = 0; j < NEFF; j++) begin : g_col
			assign thr[r][j] = mult_fact_sat(r, j);
		end
	end

	logic              en;
	logic              busy_q;
	logic              first_q;
	logic              err_q;
	logic [SIZE_W-1:0] left_q;
	logic [RANK_W-1:0] rank_q;

	logic              v_s1;
	logic              first_s1;
	logic              last_s1;
	logic              err_s1;
	logic [IW-1:0]     q_s1;

	logic               out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               last_q;
	logic               rank_err_q;
	logic [NEFF-1:0]    mask_q;

	logic [SIZE_W-1:0] rest;
	logic [IW-1:0]     rest_i;
	logic [NEFF-1:0]   ge;
	logic [IW-1:0]     q;
	logic [RANK_W-1:0] rem;

	logic [NEFF-1:0]    base;
	logic [NEFF-1:0]    unused;
	logic [NEFF-1:0]    pre;
	logic [NEFF-1:0]    hit;
	logic [DIGIT_W-1:0] dsel;

	assign en      = !out_valid_q || pop;
	assign job_pop = en && !busy_q && job_valid;

	// quotient of the rank by rest! as a count of passed multiples
	always_comb begin
		rest   = left_q - 1'b1;
		rest_i = rest[IW-1:0];
		ge     = '0;
		for (int j = 1; j < NEFF; j++) begin
			ge[j] = ({1'b0, rank_q} >= thr[rest_i][j]);
		end
		q   = IW'($countones(ge));
		rem = rank_q - thr[rest_i][q][RANK_W-1:0];
	end

	// q-th unused element
	always_comb begin
		base   = first_s1 ? '0 : mask_q;
		unused = ~base;
		hit    = '0;
		dsel   = '0;
		for (int j = 0; j < NEFF; j++) begin
			pre = '0;
			for (int i = 0; i < j; i++) begin
				pre[i] = unused[i];
			end
			hit[j] = unused[j] && (IW'($countones(pre)) == q_s1);
			dsel = dsel | (hit[j] ? DIGIT_W'(j + 1) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			first_q     <= 1'b0;
			left_q      <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= busy_q;
			out_valid_q <= v_s1;
			if (busy_q) begin
				left_q  <= rest;
				busy_q  <= (left_q != SIZE_W'(1));
				first_q <= 1'b0;
			end else if (job_valid) begin
				left_q  <= job.n;
				busy_q  <= 1'b1;
				first_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (busy_q) begin
				rank_q   <= rem;
				q_s1     <= q;
				first_s1 <= first_q;
				last_s1  <= (left_q == SIZE_W'(1));
				err_s1   <= err_q;
			end else if (job_valid) begin
				rank_q <= job.rank;
				err_q  <= job.err;
			end
			if (v_s1) begin
				mask_q     <= base | hit;
				digit_q    <= dsel;
				last_q     <= last_s1;
				rank_err_q <= err_s1;
			end
		end
	end

	assign empty      = !out_valid_q;
	assign digit      = digit_q;
	assign last_digit = last_q;
	assign rank_error = rank_err_q;

endmodule

// ===== rtl/kth_permutation_unrank_core.sv =====
// kth_permutation_unrank_core: top level, front classifier with job queue and
// back digit sequencer. Depends on kpu_pkg, kpu_front, kpu_back.
//
//  channel   ports                          handshake
//  input     perm_size, perm_rank           push / full
//  result    digit, last_digit, rank_error  empty / pop
//
// an item of size n takes a load step in the digit sequencer, then one digit
// per cycle from the quotient unit while no result is held; the first digit goes
// through the queue slot, load, quotient and result registers. size zero is
// dropped at the front. the two-entry job queue takes items while the sequencer
// works; a held result stalls the whole sequencer. no clearing pass after reset.
`timescale 1ns / 1ps

module kth_permutation_unrank_core
	import kpu_pkg::*;
#(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [SIZE_W-1:0]  perm_size,
	input  logic [RANK_W-1:0]  perm_rank,
	output logic               empty,
	input  logic               pop,
	output logic [DIGIT_W-1:0] digit,
	output logic               last_digit,
	output logic               rank_error
);

	logic job_valid;
	logic job_pop;
	job_t job;

	kpu_front #(
		.MAX_N(MAX_N)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.perm_size(perm_size),
		.perm_rank(perm_rank),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job)
	);

	kpu_back #(
		.MAX_N(MAX_N)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.empty     (empty),
		.pop       (pop),
		.digit     (digit),
		.last_digit(last_digit),
		.rank_error(rank_error)
	);

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for kth_permutation_unrank_core; items go in through a
// push/full queue port and permutation digits are popped and checked against an unranker
// built into the bench. Depends on kpu_pkg and the core rtl.
`timescale 1ns / 1ps

module tb;
	import kpu_pkg::*;

	localparam int MAX_N     = MAX_N_DEF;
	localparam int RAND_ITEMS = 85;
	localparam int HOLD_LEN  = 150;
	localparam int HOLD_AT   = 24;
	localparam int DRAIN_CYC = 40;

	typedef struct {
		logic [SIZE_W-1:0] size;
		logic [RANK_W-1:0] rank;
	} perm_req_t;

	typedef struct {
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               err;
	} perm_digit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [SIZE_W-1:0]  perm_size = '0;
	logic [RANK_W-1:0]  perm_rank = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [DIGIT_W-1:0] digit;
	logic               last_digit;
	logic               rank_error;

	perm_req_t   items_to_send[$];
	perm_digit_t digits_due[$];
	perm_digit_t want;
	perm_req_t   next_item;

	int fail_cnt = 0;
	int items_sent = 0;
	int bad_rank_items = 0;
	int zero_size_items = 0;
	int digits_checked = 0;
	int send_gap = 0;
	int pop_stall = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	kth_permutation_unrank_core #(
		.MAX_N(MAX_N)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.perm_size(perm_size),
		.perm_rank(perm_rank),
		.empty(empty),
		.pop(pop),
		.digit(digit),
		.last_digit(last_digit),
		.rank_error(rank_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint fact(input int n);
		longint f;
		f = 1;
		for (int i = 2; i <= n; i++) begin
			f = f * i;
		end
		return f;
	endfunction

	// mostly back to back, sometimes a short gap, now and then a long pause
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 24);
	endfunction

	// decode the rank into digits via the factorial number system
	function automatic void unrank_to_digits(input logic [SIZE_W-1:0] sz,
			input logic [RANK_W-1:0] rk);
		int          n;
		int          left;
		int          seen;
		int          d;
		longint      rest;
		longint      f;
		longint      q;
		bit          bad;
		bit [15:0]   taken;
		perm_digit_t e;
		n = (sz > MAX_N) ? MAX_N : int'(sz);
		if (n == 0) begin
			zero_size_items++;
			return;
		end
		bad = (rk == 0) || (longint'(rk) > fact(n));
		if (bad) begin
			bad_rank_items++;
		end
		rest = bad ? 0 : longint'(rk) - 1;
		taken = '0;
		for (int pos = 0; pos < n; pos++) begin
			left = n - pos - 1;
			f = fact(left);
			q = rest / f;
			rest = rest % f;
			d = 0;
			seen = 0;
			for (int j = 1; j <= n; j++) begin
				if (!taken[j]) begin
					if (seen == q && d == 0) begin
						d = j;
					end
					seen++;
				end
			end
			taken[d] = 1'b1;
			e.digit = DIGIT_W'(d);
			e.last = (left == 0);
			e.err = bad;
			digits_due.insert(digits_due.size(), e);
		end
	endfunction

	task automatic add_item(input int sz, input int rk);
		perm_req_t req;
		req.size = SIZE_W'(sz);
		req.rank = RANK_W'(rk);
		items_to_send.insert(items_to_send.size(), req);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			perm_size <= '0;
			perm_rank <= '0;
		end else begin
			if (push && !full) begin
				unrank_to_digits(perm_size, perm_rank);
				items_sent++;
			end
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					next_item = items_to_send.pop_front();
					push <= 1'b1;
					perm_size <= next_item.size;
					perm_rank <= next_item.rank;
					send_gap = draw_gap();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (digits_due.size() == 0) begin
					$display("%0t: unexpected digit %0d last %0b err %0b", $time,
						digit, last_digit, rank_error);
					fail_cnt++;
				end else begin
					want = digits_due.pop_front();
					if (digit !== want.digit) begin
						$display("%0t: digit expected %0d got %0d", $time, want.digit, digit);
						fail_cnt++;
					end
					if (last_digit !== want.last) begin
						$display("%0t: last_digit expected %0b got %0b", $time, want.last,
							last_digit);
						fail_cnt++;
					end
					if (rank_error !== want.err) begin
						$display("%0t: rank_error expected %0b got %0b", $time, want.err,
							rank_error);
						fail_cnt++;
					end
				end
				digits_checked++;
				if (digits_checked == HOLD_AT && !held_once) begin
					held_once = 1'b1;
					hold_left = HOLD_LEN;
				end else begin
					pop_stall = draw_gap();
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_stall > 0) begin
				pop_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		int     counted;
		int     sel;
		int     sz;
		int     n;
		longint top;
		int     rk;
		int     total_items;
		// corners: sizes, rank bounds, saturation, remainder going to zero early
		add_item(0, 5);
		add_item(1, 1);
		add_item(1, 0);
		add_item(1, 2);
		add_item(2, 1);
		add_item(2, 2);
		add_item(2, 3);
		add_item(3, 4);
		add_item(4, 7);
		add_item(4, 24);
		add_item(4, 25);
		add_item(9, 1);
		add_item(9, 181440);
		add_item(9, 362880);
		add_item(9, 362881);
		add_item(9, 524287);
		add_item(9, 0);
		add_item(15, 100);
		add_item(10, 362880);
		add_item(12, 0);
		add_item(14, 524287);
		add_item(0, 0);
		add_item(8, 40320);
		counted = 0;
		while (counted < RAND_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				add_item(0, $urandom_range(0, 524287));
			end else begin
				sz = (sel < 10) ? $urandom_range(10, 15) : $urandom_range(1, 9);
				n = (sz > MAX_N) ? MAX_N : sz;
				top = fact(n);
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					rk = $urandom_range(1, int'(top));
				end else if (sel < 86) begin
					rk = 0;
				end else if (sel < 93) begin
					rk = $urandom_range(int'(top) + 1, int'(top) + 8);
				end else begin
					rk = $urandom_range(int'(top) + 1, 524287);
				end
				add_item(sz, rk);
				counted++;
			end
		end
		total_items = items_to_send.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (items_sent < total_items) begin
			@(posedge clk);
		end
		while (digits_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYC) @(posedge clk);
		$display("run: %0d items sent, %0d with a bad rank, %0d of size zero",
			items_sent, bad_rank_items, zero_size_items);
		$display("run: %0d digits popped, one long output hold-off with input back-pressure",
			digits_checked);
		if (fail_cnt == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
